### rtl/core/stp_pkg.sv
// Shared codes, types and defaults of the software timer pool.
package stp_pkg;

	parameter int NUM_TIMERS_DEF = 8;
	parameter int MAX_RESULTS = 8;

	// Item kinds.
	parameter logic [2:0] KIND_TICK  = 3'd0;
	parameter logic [2:0] KIND_START = 3'd1;
	parameter logic [2:0] KIND_STOP  = 3'd2;
	parameter logic [2:0] KIND_QUERY = 3'd3;
	parameter logic [2:0] KIND_POLL  = 3'd4;

	// Result status codes.
	parameter logic [1:0] STAT_OK        = 2'd0;
	parameter logic [1:0] STAT_BAD_PARAM = 2'd1;
	parameter logic [1:0] STAT_NO_SLOT   = 2'd2;
	parameter logic [1:0] STAT_NOT_FOUND = 2'd3;

	// Slot states.
	parameter logic [1:0] SS_INACTIVE = 2'd0;
	parameter logic [1:0] SS_ACTIVE   = 2'd1;
	parameter logic [1:0] SS_PENDING  = 2'd2;

	// One entry of the slot record memory.
	typedef struct packed {
		logic        rep;
		logic [31:0] start;
		logic [31:0] interval;
	} stp_rec_t;

endpackage

### rtl/core/stp_in_if.sv
// Request channel of the software timer pool.
interface stp_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] interval;
	logic        repeat_req;
	logic [2:0]  slot;

	modport source (output valid, output kind, output interval, output repeat_req,
		output slot, input ready);
	modport sink (input valid, input kind, input interval, input repeat_req,
		input slot, output ready);
endinterface

### rtl/core/stp_out_if.sv
// Result channel of the software timer pool.
interface stp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  slot_id;
	logic        active;
	logic        fired;
	logic [31:0] tick_count;
	logic        last;

	modport source (output valid, output status, output slot_id, output active,
		output fired, output tick_count, output last, input ready);
	modport sink (input valid, input status, input slot_id, input active,
		input fired, input tick_count, input last, output ready);
endinterface

### rtl/core/software_timer_pool.sv
// Software timer pool: slot states in flops, slot records in one synchronous memory.
// Stop, query and start pass through an execute state to a registered result; tick and poll
// walk every slot, reading the record of each active slot (tick) or pending slot (poll)
// through the single read port of the record memory.
// One item is processed at a time; the next is taken while the last result still waits.
// Reset clears the tick count and marks all slots inactive; the record memory is not cleared.
module software_timer_pool #(
	parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	stp_in_if.sink    req,
	stp_out_if.source rsp
);
	import stp_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int RES_W = $clog2(MAX_RESULTS + 1);
	localparam logic [CNT_W-1:0] END_IDX = CNT_W'(NUM_TIMERS);
	localparam logic [RES_W-1:0] RES_MAX = RES_W'(MAX_RESULTS);
	localparam logic [RES_W-1:0] RES_LAST = RES_W'(MAX_RESULTS - 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;

	// Control and state registers.
	logic [2:0]       st_q, st_d;
	logic [2:0]       kind_q;
	logic [31:0]      interval_q;
	logic             rep_q;
	logic [2:0]       slot_q;
	logic [31:0]      ticks_q;
	logic [1:0]       state_q [NUM_TIMERS];
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [RES_W-1:0] res_cnt_q, res_cnt_d;
	logic [31:0]      sum_q;

	// Record memory and its ports.
	stp_rec_t         mem [NUM_TIMERS];
	stp_rec_t         rd_data_q;
	logic             mem_re, mem_we;
	logic [IDX_W-1:0] mem_ra, mem_wa;
	stp_rec_t         mem_wd;

	// Slot state write port.
	logic             st_we;
	logic [IDX_W-1:0] st_wa;
	logic [1:0]       st_wd;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [2:0]  out_id_q;
	logic        out_active_q;
	logic        out_fired_q;
	logic [31:0] out_ticks_q;
	logic        out_last_q;

	// Result being produced this cycle.
	logic        emit;
	logic [1:0]  e_status;
	logic [2:0]  e_id;
	logic        e_active;
	logic        e_fired;
	logic        e_last;

	logic             accept;
	logic             can_emit;
	logic [IDX_W-1:0] cur_idx;
	logic [IDX_W-1:0] slot_idx;
	logic             slot_ok;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             more_pend;
	logic [31:0]      elapsed;
	logic [31:0]      lag;
	logic             lag_ge;

	assign accept   = req.valid && req.ready;
	assign can_emit = !out_valid_q || rsp.ready;
	assign cur_idx  = idx_q[IDX_W-1:0];
	assign slot_idx = IDX_W'(slot_q);
	assign slot_ok  = int'(slot_q) < NUM_TIMERS;

	// Elapsed time of the slot under test during a tick sweep.
	assign elapsed = ticks_q - rd_data_q.start;
	// Lag of a rearmed slot behind the current tick, compared as signed values.
	assign lag     = ticks_q - sum_q;
	assign lag_ge  = $signed(lag) >= $signed(rd_data_q.interval);

	assign req.ready = (st_q == S_IDLE);

	// Lowest inactive slot for start.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int j = NUM_TIMERS - 1; j >= 0; j--) begin
			if (state_q[j] == SS_INACTIVE) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(j);
			end
		end
	end

	// Whether any slot above the current one is pending; this tells the poll
	// sweep which fired result is the final one.
	always_comb begin
		more_pend = 1'b0;
		for (int j = 0; j < NUM_TIMERS; j++) begin
			if (state_q[j] == SS_PENDING && CNT_W'(j) > idx_q) begin
				more_pend = 1'b1;
			end
		end
	end

	// Sequencer: one item at a time, a slot sweep for tick and poll.
	always_comb begin
		st_d      = st_q;
		idx_d     = idx_q;
		res_cnt_d = res_cnt_q;
		mem_re    = 1'b0;
		mem_ra    = cur_idx;
		mem_we    = 1'b0;
		mem_wa    = cur_idx;
		mem_wd    = rd_data_q;
		st_we     = 1'b0;
		st_wa     = cur_idx;
		st_wd     = SS_INACTIVE;
		emit      = 1'b0;
		e_status  = STAT_OK;
		e_id      = 3'd0;
		e_active  = 1'b0;
		e_fired   = 1'b0;
		e_last    = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				if (accept) begin
					idx_d     = '0;
					res_cnt_d = '0;
					if (req.kind == KIND_TICK || req.kind == KIND_POLL) begin
						st_d = S_SCAN;
					end else begin
						st_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_last = 1'b1;
					st_d   = S_IDLE;
					unique case (kind_q)
						KIND_START: begin
							if (interval_q == 32'd0) begin
								e_status = STAT_BAD_PARAM;
							end else if (free_found) begin
								st_we  = 1'b1;
								st_wa  = free_idx;
								st_wd  = SS_ACTIVE;
								mem_we = 1'b1;
								mem_wa = free_idx;
								mem_wd = '{rep: rep_q, start: ticks_q, interval: interval_q};
								e_id   = 3'(free_idx);
							end else begin
								e_status = STAT_NO_SLOT;
							end
						end
						KIND_STOP: begin
							if (slot_ok && state_q[slot_idx] != SS_INACTIVE) begin
								st_we = 1'b1;
								st_wa = slot_idx;
								st_wd = SS_INACTIVE;
							end else begin
								e_status = STAT_NOT_FOUND;
							end
						end
						KIND_QUERY: begin
							e_active = slot_ok && (state_q[slot_idx] == SS_ACTIVE);
						end
						default: begin
							e_status = STAT_BAD_PARAM;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (idx_q == END_IDX || (kind_q == KIND_POLL && res_cnt_q == RES_MAX)) begin
					// Sweep done. A poll that fired has already flagged its final result.
					if (kind_q == KIND_POLL && res_cnt_q != '0) begin
						st_d = S_IDLE;
					end else if (can_emit) begin
						emit   = 1'b1;
						e_last = 1'b1;
						st_d   = S_IDLE;
					end
				end else if ((kind_q == KIND_TICK && state_q[cur_idx] == SS_ACTIVE) ||
					(kind_q == KIND_POLL && state_q[cur_idx] == SS_PENDING)) begin
					mem_re = 1'b1;
					st_d   = S_RD;
				end else begin
					idx_d = CNT_W'(idx_q + 1'b1);
				end
			end
			S_RD: begin
				if (kind_q == KIND_TICK) begin
					if (elapsed >= rd_data_q.interval) begin
						st_we = 1'b1;
						st_wd = SS_PENDING;
					end
					idx_d = CNT_W'(idx_q + 1'b1);
					st_d  = S_SCAN;
				end else begin
					st_d = S_UPD;
				end
			end
			S_UPD: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_fired = 1'b1;
					e_id    = 3'(cur_idx);
					e_last  = (res_cnt_q == RES_LAST) || !more_pend;
					st_we   = 1'b1;
					if (rd_data_q.rep) begin
						st_wd  = SS_ACTIVE;
						mem_we = 1'b1;
						mem_wd = '{rep: 1'b1, start: (lag_ge ? ticks_q : sum_q),
							interval: rd_data_q.interval};
					end else begin
						st_wd = SS_INACTIVE;
					end
					idx_d     = CNT_W'(idx_q + 1'b1);
					res_cnt_d = RES_W'(res_cnt_q + 1'b1);
					st_d      = S_SCAN;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	// Control registers and slot states.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			idx_q       <= '0;
			res_cnt_q   <= '0;
			ticks_q     <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < NUM_TIMERS; j++) begin
				state_q[j] <= SS_INACTIVE;
			end
		end else begin
			st_q      <= st_d;
			idx_q     <= idx_d;
			res_cnt_q <= res_cnt_d;
			if (accept && req.kind == KIND_TICK) begin
				ticks_q <= ticks_q + 32'd1;
			end
			if (st_we) begin
				state_q[st_wa] <= st_wd;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= req.kind;
			interval_q <= req.interval;
			rep_q      <= req.repeat_req;
			slot_q     <= req.slot;
		end
		if (st_q == S_RD) begin
			sum_q <= rd_data_q.start + rd_data_q.interval;
		end
		if (emit) begin
			out_status_q <= e_status;
			out_id_q     <= e_id;
			out_active_q <= e_active;
			out_fired_q  <= e_fired;
			out_ticks_q  <= ticks_q;
			out_last_q   <= e_last;
		end
	end

	// Slot record memory, one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot_id    = out_id_q;
	assign rsp.active     = out_active_q;
	assign rsp.fired      = out_fired_q;
	assign rsp.tick_count = out_ticks_q;
	assign rsp.last       = out_last_q;

	// An accepted item always leaves the sequencer busy in the cycle after the transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q != S_IDLE))
		else $error("sequencer idle right after a transfer");

	// The tick count moves only on an accepted tick.
	a_ticks_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && req.kind == KIND_TICK) |=> $stable(ticks_q))
		else $error("tick count changed without a tick");

	// A poll never services more slots than it may report.
	a_poll_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_UPD) |-> (res_cnt_q < RES_MAX))
		else $error("poll serviced too many slots");

endmodule

### tb/software_timer_pool_tb.sv
// Self-checking testbench for the software timer pool: directed, stall and random traffic.
`timescale 1ns / 100ps

module software_timer_pool_tb;
	import stp_pkg::*;

	// The pool is built with its default slot count. Every prediction below is
	// sized from the same package constant so the two cannot drift apart.
	localparam int SLOT_COUNT = NUM_TIMERS_DEF;

	// Item kinds 5 to 7 are not defined. The block answers them with a bad
	// parameter status and leaves its state alone.
	localparam logic [2:0] KIND_RESERVED_LO = 3'd5;

	// The stimulus stops after about this many request transfers. The last
	// stretch runs with no idling on either side.
	localparam int TOTAL_ITEMS = 480;
	localparam int QUIET_TAIL = 80;

	// The long receiver hold-off fills the block and stalls its request side.
	localparam int LONG_HOLD_CYCLES = 250;

	// The watchdog limit covers the long hold-off several times over. Without
	// the hold-off, the worst gap is the longest random stall on each side plus
	// the work of a full poll.
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	// One request as the block sees it.
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] interval;
		logic        rep;
		logic [2:0]  slot;
	} timer_item_t;

	// One result as the block returns it.
	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  slot_id;
		logic        active;
		logic        fired;
		logic [31:0] tick_count;
		logic        last;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n;

	stp_in_if  req_ch ();
	stp_out_if rsp_ch ();

	software_timer_pool DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	// Shadow copy of the pool. It is advanced once per accepted request, in
	// transfer order, which is also the order in which the block works.
	logic [31:0] tick_now;
	logic [1:0]  slot_mode   [SLOT_COUNT];
	logic        slot_rearm  [SLOT_COUNT];
	logic [31:0] slot_base   [SLOT_COUNT];
	logic [31:0] slot_period [SLOT_COUNT];

	// Results predicted but not yet seen on the result channel, oldest first.
	timer_result_t awaited_timer_results[$];

	int  mismatch_count = 0;
	int  results_seen = 0;
	int  items_sent = 0;

	// Shared between the sender and the receiver: idle_on enables random idle
	// bursts on both sides, and a nonzero hold request makes the receiver drop
	// ready for the requested hold-off.
	bit  idle_on = 1'b0;
	int  sink_hold_request = 0;

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Every result carries the tick count as it stands after the item.
	function automatic void push_timer_result(input logic [1:0] status, input logic [2:0] id,
			input logic act, input logic fire, input logic lst);
		timer_result_t r;
		r.status     = status;
		r.slot_id    = id;
		r.active     = act;
		r.fired      = fire;
		r.tick_count = tick_now;
		r.last       = lst;
		awaited_timer_results.push_back(r);
	endfunction

	function automatic void predict_timer_item(input timer_item_t item);
		int          i;
		int          fired_count;
		logic [31:0] elapsed;
		bit          claimed;
		case (item.kind)
			KIND_TICK: begin
				// The counter wraps modulo 2^32, and so does the elapsed time.
				tick_now = tick_now + 32'd1;
				for (i = 0; i < SLOT_COUNT; i++) begin
					elapsed = tick_now - slot_base[i];
					if (slot_mode[i] == SS_ACTIVE && elapsed >= slot_period[i])
						slot_mode[i] = SS_PENDING;
				end
				push_timer_result(STAT_OK, 3'd0, 1'b0, 1'b0, 1'b1);
			end
			KIND_START: begin
				claimed = 1'b0;
				if (item.interval == 32'd0) begin
					push_timer_result(STAT_BAD_PARAM, 3'd0, 1'b0, 1'b0, 1'b1);
				end else begin
					// The lowest inactive slot is taken.
					for (i = 0; i < SLOT_COUNT; i++) begin
						if (!claimed && slot_mode[i] == SS_INACTIVE) begin
							claimed        = 1'b1;
							slot_mode[i]   = SS_ACTIVE;
							slot_rearm[i]  = item.rep;
							slot_base[i]   = tick_now;
							slot_period[i] = item.interval;
							push_timer_result(STAT_OK, 3'(i), 1'b0, 1'b0, 1'b1);
						end
					end
					if (!claimed)
						push_timer_result(STAT_NO_SLOT, 3'd0, 1'b0, 1'b0, 1'b1);
				end
			end
			KIND_STOP: begin
				// A pending slot is cleared just like an active one.
				if (int'(item.slot) < SLOT_COUNT && slot_mode[item.slot] != SS_INACTIVE) begin
					slot_mode[item.slot] = SS_INACTIVE;
					push_timer_result(STAT_OK, 3'd0, 1'b0, 1'b0, 1'b1);
				end else begin
					push_timer_result(STAT_NOT_FOUND, 3'd0, 1'b0, 1'b0, 1'b1);
				end
			end
			KIND_QUERY: begin
				// Only a slot that is strictly active answers true.
				push_timer_result(STAT_OK, 3'd0,
					int'(item.slot) < SLOT_COUNT && slot_mode[item.slot] == SS_ACTIVE,
					1'b0, 1'b1);
			end
			KIND_POLL: begin
				fired_count = 0;
				for (i = 0; i < SLOT_COUNT && fired_count < MAX_RESULTS; i++) begin
					if (slot_mode[i] == SS_PENDING) begin
						if (slot_rearm[i]) begin
							// Rearm one period on. If the slot still lags by a
							// whole period or more (signed view of the wrapped
							// lag and the period), restart it from now.
							slot_base[i] = slot_base[i] + slot_period[i];
							elapsed = tick_now - slot_base[i];
							if ($signed(elapsed) >= $signed(slot_period[i]))
								slot_base[i] = tick_now;
							slot_mode[i] = SS_ACTIVE;
						end else begin
							slot_mode[i] = SS_INACTIVE;
						end
						push_timer_result(STAT_OK, 3'(i), 1'b0, 1'b1, 1'b0);
						fired_count++;
					end
				end
				// A poll that finds nothing still answers once.
				if (fired_count == 0)
					push_timer_result(STAT_OK, 3'd0, 1'b0, 1'b0, 1'b1);
				else
					awaited_timer_results[awaited_timer_results.size() - 1].last = 1'b1;
			end
			default: begin
				push_timer_result(STAT_BAD_PARAM, 3'd0, 1'b0, 1'b0, 1'b1);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------------

	// Outputs are sampled at the rising edge, before the block updates them,
	// so the comparison sees exactly the values of the transfer.
	always @(posedge clk) begin : result_check
		timer_result_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			results_seen++;
			if (awaited_timer_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d arrived with no result outstanding: status=%0d slot=%0d",
						results_seen, rsp_ch.status, rsp_ch.slot_id);
			end else begin
				want = awaited_timer_results.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.slot_id !== want.slot_id ||
						rsp_ch.active !== want.active || rsp_ch.fired !== want.fired ||
						rsp_ch.tick_count !== want.tick_count || rsp_ch.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result %0d expected: status=%0d slot=%0d active=%0b fired=%0b ticks=%0d last=%0b",
							results_seen, want.status, want.slot_id, want.active, want.fired,
							want.tick_count, want.last);
						$display("result %0d actual:   status=%0d slot=%0d active=%0b fired=%0b ticks=%0d last=%0b",
							results_seen, rsp_ch.status, rsp_ch.slot_id, rsp_ch.active,
							rsp_ch.fired, rsp_ch.tick_count, rsp_ch.last);
					end
				end
			end
		end
	end

	// The run is declared stuck when no transfer happens on either channel for
	// too long. This also catches a result that never comes.
	always @(posedge clk) begin : stall_watchdog
		int quiet_cycles;
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Result receiver
	// ---------------------------------------------------------------------

	// Each loop pass makes exactly one assignment to ready and then waits on
	// the clock, so ready never gets two updates in one step.
	initial begin : result_sink
		int hold;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (sink_hold_request != 0) begin
				hold = sink_hold_request;
				sink_hold_request = 0;
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------

	function automatic timer_item_t make_item(input logic [2:0] kind,
			input logic [31:0] interval, input logic rep, input logic [2:0] slot);
		timer_item_t item;
		item.kind     = kind;
		item.interval = interval;
		item.rep      = rep;
		item.slot     = slot;
		return item;
	endfunction

	// Mostly short periods so that slots really expire; now and then a zero,
	// an extreme or a fully random period so that every bit is exercised.
	function automatic logic [31:0] pick_interval();
		int r;
		r = $urandom_range(0, 31);
		if (r == 0)
			return 32'd0;
		else if (r == 1)
			return 32'hFFFF_FFFF;
		else if (r == 2)
			return 32'h8000_0000;
		else if (r < 7)
			return $urandom();
		return $urandom_range(1, 12);
	endfunction

	// Ticks dominate so that time moves; polls are frequent enough that
	// several slots are often pending at once. Unused fields stay random.
	function automatic timer_item_t random_timer_item();
		int          r;
		logic [2:0]  kind;
		r = $urandom_range(0, 99);
		if (r < 35)
			kind = KIND_TICK;
		else if (r < 55)
			kind = KIND_START;
		else if (r < 65)
			kind = KIND_STOP;
		else if (r < 75)
			kind = KIND_QUERY;
		else if (r < 92)
			kind = KIND_POLL;
		else
			kind = 3'($urandom_range(int'(KIND_RESERVED_LO), 7));
		return make_item(kind, pick_interval(), 1'($urandom_range(0, 1)),
			3'($urandom_range(0, 7)));
	endfunction

	// Drops valid and lets the given number of edges go by.
	task automatic pause_sender(input int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Offers one request and holds it until the transfer. The prediction is
	// made at the accepting edge. On return the caller is at that edge and
	// may offer the next request at once, keeping valid high.
	task automatic send_timer_item(input timer_item_t item);
		if (idle_on && $urandom_range(0, 4) == 0)
			pause_sender($urandom_range(1, 16));
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= item.kind;
		req_ch.interval   <= item.interval;
		req_ch.repeat_req <= item.rep;
		req_ch.slot       <= item.slot;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		predict_timer_item(item);
		items_sent++;
	endtask

	task automatic wait_all_results();
		while (awaited_timer_results.size() != 0)
			@(posedge clk);
	endtask

	// Clears every slot, starts all of them with short periods, lets them all
	// expire and polls once, so the poll returns its largest burst of results.
	// A longer run of ticks leaves repeating slots far enough behind that
	// they restart from the current tick.
	task automatic run_fill_and_fire();
		int s;
		for (s = 0; s < SLOT_COUNT; s++)
			send_timer_item(make_item(KIND_STOP, $urandom(), 1'($urandom_range(0, 1)), 3'(s)));
		for (s = 0; s < SLOT_COUNT; s++)
			send_timer_item(make_item(KIND_START, $urandom_range(1, 4),
				1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
		repeat ($urandom_range(4, 9))
			send_timer_item(make_item(KIND_TICK, $urandom(), 1'($urandom_range(0, 1)),
				3'($urandom_range(0, 7))));
		send_timer_item(make_item(KIND_POLL, $urandom(), 1'($urandom_range(0, 1)),
			3'($urandom_range(0, 7))));
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Walks every kind and every status: an empty poll, lookups of an unused
	// slot, a zero period, the largest periods, a full pool, stops of active,
	// pending and inactive slots, a query of a pending slot, a poll that
	// rearms, restarts and clears slots, and the undefined kinds.
	task automatic test_directed();
		int n;
		int k;
		idle_on = 1'b1;
		send_timer_item(make_item(KIND_POLL, 32'd0, 1'b0, 3'd0));
		send_timer_item(make_item(KIND_QUERY, 32'd0, 1'b0, 3'd7));
		send_timer_item(make_item(KIND_STOP, 32'd0, 1'b0, 3'd7));
		send_timer_item(make_item(KIND_START, 32'd0, 1'b1, 3'd0));
		send_timer_item(make_item(KIND_START, 32'd1, 1'b1, 3'd0));
		send_timer_item(make_item(KIND_START, 32'hFFFF_FFFF, 1'b0, 3'd5));
		send_timer_item(make_item(KIND_START, 32'h8000_0000, 1'b1, 3'd2));
		send_timer_item(make_item(KIND_START, 32'd2, 1'b0, 3'd0));
		for (n = 0; n < 4; n++)
			send_timer_item(make_item(KIND_START, 32'd1, n[0], 3'd7));
		// Every slot is taken now.
		send_timer_item(make_item(KIND_START, 32'd5, 1'b1, 3'd0));
		send_timer_item(make_item(KIND_QUERY, 32'd0, 1'b0, 3'd0));
		send_timer_item(make_item(KIND_STOP, 32'd0, 1'b0, 3'd2));
		send_timer_item(make_item(KIND_STOP, 32'd0, 1'b0, 3'd2));
		send_timer_item(make_item(KIND_START, 32'd1, 1'b0, 3'd0));
		send_timer_item(make_item(KIND_TICK, 32'd0, 1'b0, 3'd0));
		send_timer_item(make_item(KIND_TICK, 32'd0, 1'b0, 3'd0));
		// Slot 0 has expired and is pending, so it must not read as active.
		send_timer_item(make_item(KIND_QUERY, 32'd0, 1'b0, 3'd0));
		send_timer_item(make_item(KIND_STOP, 32'd0, 1'b0, 3'd5));
		send_timer_item(make_item(KIND_TICK, 32'd0, 1'b0, 3'd0));
		send_timer_item(make_item(KIND_POLL, 32'd0, 1'b0, 3'd0));
		for (k = int'(KIND_RESERVED_LO); k < 8; k++)
			send_timer_item(make_item(3'(k), $urandom(), 1'b1, 3'd7));
	endtask

	// The receiver holds off for a long stretch while requests keep coming
	// back to back, so the block fills up and stops taking requests.
	task automatic test_output_backpressure();
		idle_on = 1'b0;
		sink_hold_request = LONG_HOLD_CYCLES;
		repeat (24)
			send_timer_item(random_timer_item());
		pause_sender(1);
		wait_all_results();
	endtask

	// A full burst of expiries followed by a pause in which nothing is sent
	// until every outstanding result has come back.
	task automatic test_drain_pause();
		idle_on = 1'b1;
		run_fill_and_fire();
		pause_sender(1);
		wait_all_results();
		send_timer_item(make_item(KIND_POLL, $urandom(), 1'b0, 3'd0));
	endtask

	// Random scenarios until the item budget is spent: mostly mixed bursts,
	// with full-pool expiry runs in between. Idling is switched per scenario
	// and is off for the closing stretch.
	task automatic test_random_traffic();
		while (items_sent < TOTAL_ITEMS) begin
			idle_on = (items_sent < TOTAL_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				run_fill_and_fire();
			else
				repeat ($urandom_range(10, 30))
					send_timer_item(random_timer_item());
		end
		idle_on = 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------

	initial begin : run_tests
		int i;
		// Every input is known from time zero; the shadow pool starts out
		// the way reset leaves the block.
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.kind       = KIND_TICK;
		req_ch.interval   = 32'd0;
		req_ch.repeat_req = 1'b0;
		req_ch.slot       = 3'd0;
		tick_now = 32'd0;
		for (i = 0; i < SLOT_COUNT; i++) begin
			slot_mode[i]   = SS_INACTIVE;
			slot_rearm[i]  = 1'b0;
			slot_base[i]   = 32'd0;
			slot_period[i] = 32'd0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_output_backpressure();
		test_drain_pause();
		test_random_traffic();

		// Let the last results come, then give the block time to show any
		// result that was not asked for.
		pause_sender(1);
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
